[design/broadcast_retry_scheduler_assert.svh]
// assertion macros for the broadcast retry scheduler
`ifndef BROADCAST_RETRY_SCHEDULER_ASSERT_SVH
`define BROADCAST_RETRY_SCHEDULER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BRS_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define BRS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/brs_pkg.sv]
// types and constants shared by the broadcast retry scheduler
package brs_pkg;

	// item kinds
	localparam logic [1:0] MODE_START   = 2'd0;
	localparam logic [1:0] MODE_STOP    = 2'd1;
	localparam logic [1:0] MODE_SERVICE = 2'd2;

	// sink outcomes
	localparam logic [1:0] SINK_ACCEPTED = 2'd0;
	localparam logic [1:0] SINK_BUSY     = 2'd1;
	localparam logic [1:0] SINK_NO_ROOM  = 2'd2;
	localparam logic [1:0] SINK_ERROR    = 2'd3;

	// dispositions
	localparam logic [2:0] DISP_NONE      = 3'd0;
	localparam logic [2:0] DISP_NOT_DUE   = 3'd1;
	localparam logic [2:0] DISP_DEFERRED  = 3'd2;
	localparam logic [2:0] DISP_SUBMITTED = 3'd3;
	localparam logic [2:0] DISP_FAILED    = 3'd4;

	// error codes
	localparam logic [3:0] ERR_NONE      = 4'd0;
	localparam logic [3:0] ERR_POLICY    = 4'd1;
	localparam logic [3:0] ERR_CLOCK     = 4'd2;
	localparam logic [3:0] ERR_EXHAUSTED = 4'd3;
	localparam logic [3:0] ERR_NO_FIX    = 4'd4;
	localparam logic [3:0] ERR_ENCODE    = 4'd5;
	localparam logic [3:0] ERR_NOT_READY = 4'd6;
	localparam logic [3:0] ERR_FULL      = 4'd7;
	localparam logic [3:0] ERR_SINK_FAIL = 4'd8;

	// configuration register indexes
	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_CADENCE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RETRY   = 2'd1;

	localparam logic [31:0] CADENCE_RESET = 32'd1000;
	localparam logic [31:0] RETRY_RESET   = 32'd250;

	// counter slots
	localparam int unsigned CNT_NUM      = 6;
	localparam int unsigned CNT_SUBMIT   = 0;
	localparam int unsigned CNT_BACKPR   = 1;
	localparam int unsigned CNT_SUPPRESS = 2;
	localparam int unsigned CNT_FAILURE  = 3;
	localparam int unsigned CNT_SERVICE  = 4;
	localparam int unsigned CNT_START    = 5;

	typedef struct packed {
		logic [1:0]  mode;
		logic [63:0] now_time;
		logic        fix_usable;
		logic        encode_ok;
		logic [1:0]  sink_status;
	} brs_in_t;

	typedef struct packed {
		logic [2:0]  disposition;
		logic [3:0]  error_code;
		logic [63:0] next_due;
		logic        is_active;
		logic        clock_fault;
		logic        exhausted;
		logic [31:0] submitted_count;
		logic [31:0] backpressure_count;
		logic [31:0] suppressed_count;
		logic [31:0] failure_count;
		logic [31:0] service_count;
		logic [31:0] start_attempt_count;
	} brs_out_t;

	// scheduler state apart from the counters
	typedef struct packed {
		logic        active;
		logic [63:0] next_attempt;
		logic [63:0] last_time;
		logic        time_seen;
		logic        clock_fault;
		logic        exhausted;
		logic [3:0]  last_err;
	} brs_state_t;

endpackage

[design/brs_core.sv]
// next-state and result logic for one item
module brs_core import brs_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  brs_in_t                             item,
	input  brs_state_t                          st,
	input  logic [CNT_NUM-1:0][COUNT_WIDTH-1:0] cnt,
	input  logic [31:0]                         cadence,
	input  logic [31:0]                         retry,
	output brs_state_t                          st_nxt,
	output logic [CNT_NUM-1:0][COUNT_WIDTH-1:0] cnt_nxt,
	output brs_out_t                            res
);

	localparam logic [COUNT_WIDTH:0] CNT_MAX = {1'b0, {COUNT_WIDTH{1'b1}}};

	logic [CNT_NUM-1:0][1:0] inc;
	logic [COUNT_WIDTH:0]    csum [CNT_NUM];
	logic                    policy_bad;
	logic                    regress;
	logic [3:0]              gate_err;
	logic [31:0]             delay;
	logic [64:0]             plan_sum;
	logic [2:0]              disp;
	logic [3:0]              err;
	logic [63:0]             due;
	logic                    submit;

	assign policy_bad = (cadence == 32'd0) || (retry == 32'd0);
	assign regress    = st.time_seen && (item.now_time < st.last_time);
	assign submit     = item.fix_usable && item.encode_ok && (item.sink_status == SINK_ACCEPTED);
	assign delay      = submit ? cadence : retry;
	assign plan_sum   = {1'b0, item.now_time} + {33'd0, delay};

	always_comb begin
		if (policy_bad) begin
			gate_err = ERR_POLICY;
		end else if (st.clock_fault) begin
			gate_err = ERR_CLOCK;
		end else if (st.exhausted) begin
			gate_err = ERR_EXHAUSTED;
		end else if (regress) begin
			gate_err = ERR_CLOCK;
		end else begin
			gate_err = ERR_NONE;
		end
	end

	always_comb begin
		st_nxt = st;
		inc    = '0;
		disp   = DISP_NONE;
		err    = st.last_err;
		due    = st.next_attempt;

		// shared gate for start and service
		if (item.mode == MODE_START || item.mode == MODE_SERVICE) begin
			if (gate_err != ERR_NONE) begin
				st_nxt.last_err = gate_err;
			end
			if (gate_err == ERR_CLOCK && !policy_bad && !st.clock_fault) begin
				st_nxt.active       = 1'b0;
				st_nxt.next_attempt = 64'd0;
				st_nxt.clock_fault  = 1'b1;
				inc[CNT_FAILURE]    = 2'd1;
			end
			if (gate_err == ERR_NONE) begin
				st_nxt.time_seen = 1'b1;
				st_nxt.last_time = item.now_time;
			end
		end

		case (item.mode)
			MODE_START: begin
				inc[CNT_START] = 2'd1;
				if (gate_err == ERR_NONE) begin
					if (!st.active) begin
						st_nxt.active       = 1'b1;
						st_nxt.next_attempt = item.now_time;
					end
					st_nxt.last_err = ERR_NONE;
				end
				err = st_nxt.last_err;
				due = st_nxt.next_attempt;
			end
			MODE_STOP: begin
				st_nxt.active       = 1'b0;
				st_nxt.next_attempt = 64'd0;
				due                 = 64'd0;
			end
			MODE_SERVICE: begin
				inc[CNT_SERVICE] = 2'd1;
				if (gate_err != ERR_NONE) begin
					disp = DISP_FAILED;
					err  = gate_err;
					due  = 64'd0;
				end else if (!st.active) begin
					st_nxt.last_err = ERR_NONE;
					err             = ERR_NONE;
					due             = 64'd0;
				end else if (item.now_time < st.next_attempt) begin
					st_nxt.last_err = ERR_NONE;
					disp            = DISP_NOT_DUE;
					err             = ERR_NONE;
				end else begin
					disp = DISP_DEFERRED;
					if (!item.fix_usable) begin
						inc[CNT_SUPPRESS] = 2'd1;
						err               = ERR_NO_FIX;
					end else if (!item.encode_ok) begin
						inc[CNT_FAILURE] = 2'd1;
						err              = ERR_ENCODE;
					end else begin
						case (item.sink_status)
							SINK_ACCEPTED: begin
								inc[CNT_SUBMIT] = 2'd1;
								err             = ERR_NONE;
								disp            = DISP_SUBMITTED;
							end
							SINK_BUSY: begin
								inc[CNT_BACKPR] = 2'd1;
								err             = ERR_NOT_READY;
							end
							SINK_NO_ROOM: begin
								inc[CNT_BACKPR] = 2'd1;
								err             = ERR_FULL;
							end
							default: begin
								inc[CNT_FAILURE] = 2'd1;
								err              = ERR_SINK_FAIL;
							end
						endcase
					end
					st_nxt.last_err = err;
					// due time past the top of the time range
					if (plan_sum[64]) begin
						st_nxt.active       = 1'b0;
						st_nxt.next_attempt = 64'd0;
						st_nxt.exhausted    = 1'b1;
						inc[CNT_FAILURE]    = inc[CNT_FAILURE] + 2'd1;
					end else begin
						st_nxt.next_attempt = plan_sum[63:0];
					end
					due = st_nxt.next_attempt;
				end
			end
			default: begin
			end
		endcase
	end

	// saturating counters, failure may step by two
	always_comb begin
		for (int i = 0; i < CNT_NUM; i++) begin
			csum[i] = {1'b0, cnt[i]} + {{(COUNT_WIDTH-1){1'b0}}, inc[i]};
			cnt_nxt[i] = (csum[i] > CNT_MAX) ? CNT_MAX[COUNT_WIDTH-1:0]
				: csum[i][COUNT_WIDTH-1:0];
		end
	end

	always_comb begin
		res.disposition         = disp;
		res.error_code          = err;
		res.next_due            = due;
		res.is_active           = st_nxt.active;
		res.clock_fault         = st_nxt.clock_fault;
		res.exhausted           = st_nxt.exhausted;
		res.submitted_count     = 32'(cnt_nxt[CNT_SUBMIT]);
		res.backpressure_count  = 32'(cnt_nxt[CNT_BACKPR]);
		res.suppressed_count    = 32'(cnt_nxt[CNT_SUPPRESS]);
		res.failure_count       = 32'(cnt_nxt[CNT_FAILURE]);
		res.service_count       = 32'(cnt_nxt[CNT_SERVICE]);
		res.start_attempt_count = 32'(cnt_nxt[CNT_START]);
	end

endmodule

[design/broadcast_retry_scheduler.sv]
// broadcast retry scheduler top level: input register, state, result register
//
// channel  direction  handshake              word
// in       in         in_valid / in_ready    in_item (brs_in_t)
// out      out        out_valid / out_ready  out_item (brs_out_t)
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one item per cycle sustained while out takes its words; an accepted word waits in the input
// register, then state update and result register in one pass
// all scheduler state lives in flops; the 64-bit add and compares set the path
// arst_n clears state and counters and loads cadence 1000 and retry 250
// a stalled out holds its word; in still takes one word into the input register
module broadcast_retry_scheduler import brs_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  brs_in_t                in_item,
	output logic                   out_valid,
	input  logic                   out_ready,
	output brs_out_t               out_item,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]            cfg_data
);

	// input register
	logic    s1_valid_q;
	brs_in_t item_s1;

	// scheduler state and tallies
	brs_state_t                          st_q;
	brs_state_t                          st_nxt;
	logic [CNT_NUM-1:0][COUNT_WIDTH-1:0] cnt_q;
	logic [CNT_NUM-1:0][COUNT_WIDTH-1:0] cnt_nxt;

	// policy registers
	logic [31:0] cadence_q;
	logic [31:0] retry_q;

	// result register
	logic     out_valid_q;
	brs_out_t out_q;
	brs_out_t res;

	logic advance;

	// the item in the input register moves on when the result slot is free
	assign advance   = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready  = !s1_valid_q || advance;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	// policy writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cadence_q <= CADENCE_RESET;
			retry_q   <= RETRY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CADENCE: cadence_q <= cfg_data;
				REG_RETRY:   retry_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	brs_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.item    (item_s1),
		.st      (st_q),
		.cnt     (cnt_q),
		.cadence (cadence_q),
		.retry   (retry_q),
		.st_nxt  (st_nxt),
		.cnt_nxt (cnt_nxt),
		.res     (res)
	);

	// state commits in the same cycle the result is registered, so the
	// next item always sees the effect of this one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '0;
			cnt_q <= '0;
		end else if (advance) begin
			st_q  <= st_nxt;
			cnt_q <= cnt_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	`include "broadcast_retry_scheduler_assert.svh"

	// a clock fault never clears once latched
	`BRS_ASSERT_NEXT(a_fault_sticky, st_q.clock_fault, st_q.clock_fault, "clock fault latch dropped")
	// an inactive scheduler holds no pending attempt
	`BRS_ASSERT_IMPLY(a_idle_no_due, !st_q.active, st_q.next_attempt == 64'd0, "inactive with due time")
	// a full input register behind a stalled result must block new words
	`BRS_ASSERT_IMPLY(a_stall_blocks, s1_valid_q && out_valid_q && !out_ready, !in_ready, "word taken while stalled")

endmodule

[tb/sv/broadcast_retry_scheduler_tb.sv]
// self-checking testbench for the broadcast retry scheduler
module broadcast_retry_scheduler_tb import brs_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// mode value the block must leave alone
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int LIMIT_CYCLES = 200000;
	localparam int PHASE_ITEMS = 90;
	localparam int PHASE_COUNT = 8;

	// receiver stall patterns
	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_pattern_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	brs_in_t in_item;
	logic out_valid;
	logic out_ready = 1'b0;
	brs_out_t out_item;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	broadcast_retry_scheduler DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// scheduler mirror: policy, state and tallies as the block should hold them
	logic [31:0] cad_period;
	logic [31:0] rty_period;
	logic sched_active;
	logic [63:0] next_at;
	logic [63:0] last_seen_ms;
	logic seen_any_time;
	logic clk_fault;
	logic due_overflow;
	logic [3:0] last_err;
	logic [31:0] n_submit;
	logic [31:0] n_backpr;
	logic [31:0] n_suppress;
	logic [31:0] n_failure;
	logic [31:0] n_service;
	logic [31:0] n_start;

	// result words still owed by the block, oldest first
	brs_out_t predicted_words[$];
	int mismatch_count = 0;
	int cycle_count = 0;

	// stimulus bookkeeping
	logic [63:0] now_ms;
	int burst_left = 0;
	rx_pattern_t rx_pattern = RX_OPEN;
	int rx_tick = 0;

	function automatic logic [31:0] sat_inc(input logic [31:0] c);
		return (c == '1) ? c : c + 32'd1;
	endfunction

	// policy, latch and time checks shared by start and service
	function automatic logic [3:0] gate_check(input logic [63:0] now);
		if (cad_period == 32'd0 || rty_period == 32'd0) begin
			last_err = ERR_POLICY;
			return ERR_POLICY;
		end
		if (clk_fault) begin
			last_err = ERR_CLOCK;
			return ERR_CLOCK;
		end
		if (due_overflow) begin
			last_err = ERR_EXHAUSTED;
			return ERR_EXHAUSTED;
		end
		// time running backwards latches the fault and drops the schedule
		if (seen_any_time && now < last_seen_ms) begin
			sched_active = 1'b0;
			next_at = '0;
			clk_fault = 1'b1;
			last_err = ERR_CLOCK;
			n_failure = sat_inc(n_failure);
			return ERR_CLOCK;
		end
		seen_any_time = 1'b1;
		last_seen_ms = now;
		return ERR_NONE;
	endfunction

	// advances the mirror by one input word and gives the word it should produce
	function automatic brs_out_t schedule_step(input brs_in_t w);
		brs_out_t r;
		logic [2:0] disp;
		logic [3:0] err;
		logic [63:0] due;
		logic [63:0] delay;
		disp = DISP_NONE;
		err = ERR_NONE;
		due = '0;
		if (w.mode == MODE_SERVICE) begin
			n_service = sat_inc(n_service);
			err = gate_check(w.now_time);
			if (err != ERR_NONE) begin
				disp = DISP_FAILED;
			end else if (!sched_active) begin
				last_err = ERR_NONE;
			end else if (w.now_time < next_at) begin
				last_err = ERR_NONE;
				disp = DISP_NOT_DUE;
				due = next_at;
			end else begin
				// due: defer by the retry delay unless the sink took it
				delay = 64'(rty_period);
				disp = DISP_DEFERRED;
				if (!w.fix_usable) begin
					n_suppress = sat_inc(n_suppress);
					err = ERR_NO_FIX;
				end else if (!w.encode_ok) begin
					n_failure = sat_inc(n_failure);
					err = ERR_ENCODE;
				end else begin
					case (w.sink_status)
						SINK_ACCEPTED: begin
							n_submit = sat_inc(n_submit);
							err = ERR_NONE;
							disp = DISP_SUBMITTED;
							delay = 64'(cad_period);
						end
						SINK_BUSY: begin
							n_backpr = sat_inc(n_backpr);
							err = ERR_NOT_READY;
						end
						SINK_NO_ROOM: begin
							n_backpr = sat_inc(n_backpr);
							err = ERR_FULL;
						end
						default: begin
							n_failure = sat_inc(n_failure);
							err = ERR_SINK_FAIL;
						end
					endcase
				end
				last_err = err;
				// a due time past the top of 64 bits exhausts the schedule
				if (w.now_time > ~64'd0 - delay) begin
					sched_active = 1'b0;
					next_at = '0;
					if (!due_overflow) begin
						n_failure = sat_inc(n_failure);
					end
					due_overflow = 1'b1;
				end else begin
					next_at = w.now_time + delay;
				end
				due = next_at;
			end
		end else begin
			if (w.mode == MODE_START) begin
				n_start = sat_inc(n_start);
				if (gate_check(w.now_time) == ERR_NONE) begin
					// a start while active keeps the pending due time
					if (!sched_active) begin
						sched_active = 1'b1;
						next_at = w.now_time;
					end
					last_err = ERR_NONE;
				end
			end else if (w.mode == MODE_STOP) begin
				if (sched_active) begin
					sched_active = 1'b0;
					next_at = '0;
				end
			end
			// start, stop and the unused mode report the state after the word
			err = last_err;
			due = next_at;
		end
		r.disposition = disp;
		r.error_code = err;
		r.next_due = due;
		r.is_active = sched_active;
		r.clock_fault = clk_fault;
		r.exhausted = due_overflow;
		r.submitted_count = n_submit;
		r.backpressure_count = n_backpr;
		r.suppressed_count = n_suppress;
		r.failure_count = n_failure;
		r.service_count = n_service;
		r.start_attempt_count = n_start;
		return r;
	endfunction

	function automatic brs_in_t make_word(input logic [1:0] mode, input logic [63:0] now,
			input logic fix, input logic enc, input logic [1:0] sink);
		brs_in_t w;
		w.mode = mode;
		w.now_time = now;
		w.fix_usable = fix;
		w.encode_ok = enc;
		w.sink_status = sink;
		return w;
	endfunction

	// random word on a forward-moving timeline; stop and unused words carry noise
	function automatic brs_in_t random_word();
		brs_in_t w;
		int pick;
		logic [63:0] delta;
		pick = $urandom_range(0, 99);
		w = make_word(2'($urandom_range(0, 3)), {$urandom, $urandom},
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
		if (pick < 8) begin
			w.mode = MODE_STOP;
		end else if (pick < 11) begin
			w.mode = MODE_UNUSED;
		end else begin
			case ($urandom_range(0, 7))
				0: delta = '0;
				// land right on the pending due time, or one short of it
				1: delta = (next_at > now_ms) ? next_at - now_ms : '0;
				2: delta = (next_at > now_ms + 1) ? next_at - now_ms - 1 : '0;
				// long jump forward
				3: delta = {$urandom_range(0, 255), $urandom};
				default: delta = {$urandom, $urandom} % (64'(cad_period) + 64'(rty_period) + 64'd2);
			endcase
			now_ms = now_ms + delta;
			w.now_time = now_ms;
			w.mode = (pick < 24) ? MODE_START : MODE_SERVICE;
			if (w.mode == MODE_SERVICE) begin
				w.fix_usable = ($urandom_range(0, 7) != 0);
				w.encode_ok = ($urandom_range(0, 7) != 0);
				w.sink_status = $urandom_range(0, 1) ? SINK_ACCEPTED : 2'($urandom_range(0, 3));
			end
		end
		return w;
	endfunction

	// offers one word, in bursts with random gaps, and logs its prediction on acceptance
	task automatic send_word(input brs_in_t w);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_item = w;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		predicted_words.push_back(schedule_step(w));
		@(negedge clk);
	endtask

	// drop valid and let every owed word come back, plus the pipeline depth
	task automatic wait_idle();
		in_valid = 1'b0;
		while (predicted_words.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		if (idx == REG_CADENCE) begin
			cad_period = val;
		end else if (idx == REG_RETRY) begin
			rty_period = val;
		end
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// policy changes only on an idle block
	task automatic set_policy(input logic [31:0] cadence, input logic [31:0] retry);
		wait_idle();
		write_reg(REG_CADENCE, cadence);
		write_reg(REG_RETRY, retry);
	endtask

	// words that find the scheduler inactive, and the unused mode
	task automatic test_idle_items();
		now_ms = '0;
		send_word(make_word(MODE_SERVICE, now_ms, 1'b1, 1'b1, SINK_ACCEPTED));
		send_word(make_word(MODE_STOP, '1, 1'b1, 1'b1, SINK_ERROR));
		send_word(make_word(MODE_UNUSED, {$urandom, $urandom}, 1'b0, 1'b0, SINK_NO_ROOM));
	endtask

	// every due outcome in turn at the reset policy
	task automatic test_service_outcomes();
		send_word(make_word(MODE_START, now_ms, 1'b0, 1'b0, SINK_ACCEPTED));
		now_ms = now_ms + 5;
		// start while active keeps the due time at zero
		send_word(make_word(MODE_START, now_ms, 1'b0, 1'b0, SINK_ACCEPTED));
		send_word(make_word(MODE_SERVICE, now_ms, 1'b0, 1'b1, SINK_ACCEPTED));
		now_ms = now_ms + 249;
		send_word(make_word(MODE_SERVICE, now_ms, 1'b1, 1'b1, SINK_ACCEPTED));
		now_ms = now_ms + 1;
		send_word(make_word(MODE_SERVICE, now_ms, 1'b1, 1'b0, SINK_ACCEPTED));
		now_ms = now_ms + 250;
		send_word(make_word(MODE_SERVICE, now_ms, 1'b1, 1'b1, SINK_BUSY));
		now_ms = now_ms + 250;
		send_word(make_word(MODE_SERVICE, now_ms, 1'b1, 1'b1, SINK_NO_ROOM));
		now_ms = now_ms + 250;
		send_word(make_word(MODE_SERVICE, now_ms, 1'b1, 1'b1, SINK_ERROR));
		now_ms = now_ms + 250;
		send_word(make_word(MODE_SERVICE, now_ms, 1'b1, 1'b1, SINK_ACCEPTED));
		send_word(make_word(MODE_STOP, now_ms, 1'b1, 1'b1, SINK_ACCEPTED));
		now_ms = now_ms + 1000;
		send_word(make_word(MODE_SERVICE, now_ms, 1'b1, 1'b1, SINK_ACCEPTED));
	endtask

	// a zero delay in either register makes start and service fail
	task automatic test_policy_invalid();
		set_policy(32'd0, RETRY_RESET);
		now_ms = now_ms + 10;
		send_word(make_word(MODE_START, now_ms, 1'b1, 1'b1, SINK_ACCEPTED));
		send_word(make_word(MODE_SERVICE, now_ms, 1'b1, 1'b1, SINK_ACCEPTED));
		set_policy(CADENCE_RESET, 32'd0);
		send_word(make_word(MODE_SERVICE, now_ms, 1'b1, 1'b1, SINK_ACCEPTED));
		set_policy(CADENCE_RESET, RETRY_RESET);
		send_word(make_word(MODE_START, now_ms, 1'b1, 1'b1, SINK_ACCEPTED));
		send_word(make_word(MODE_SERVICE, now_ms, 1'b1, 1'b1, SINK_ACCEPTED));
	endtask

	// largest and smallest delays
	task automatic test_delay_extremes();
		set_policy('1, '1);
		now_ms = now_ms + 1000;
		send_word(make_word(MODE_SERVICE, now_ms, 1'b1, 1'b1, SINK_ACCEPTED));
		now_ms = now_ms + 1;
		send_word(make_word(MODE_SERVICE, now_ms, 1'b1, 1'b1, SINK_ACCEPTED));
		now_ms = next_at;
		send_word(make_word(MODE_SERVICE, now_ms, 1'b0, 1'b1, SINK_ACCEPTED));
		set_policy(32'd1, 32'd1);
		now_ms = next_at;
		send_word(make_word(MODE_SERVICE, now_ms, 1'b1, 1'b1, SINK_ACCEPTED));
		now_ms = now_ms + 1;
		send_word(make_word(MODE_SERVICE, now_ms, 1'b1, 1'b1, SINK_NO_ROOM));
	endtask

	// random traffic over a series of policies, extremes and invalid ones among them
	task automatic test_random_traffic();
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase)
				0: set_policy(CADENCE_RESET, RETRY_RESET);
				1: set_policy(32'd1, 32'd1);
				2: set_policy($urandom_range(1, 3000), $urandom_range(1, 3000));
				3: set_policy('1, '1);
				4: begin
					if ($urandom_range(0, 1)) begin
						set_policy(32'd0, $urandom_range(1, 500));
					end else begin
						set_policy($urandom_range(1, 500), 32'd0);
					end
				end
				5: set_policy($urandom, $urandom);
				6: set_policy(32'd1, '1);
				default: set_policy($urandom_range(1, 100), $urandom_range(1, 100));
			endcase
			repeat (PHASE_ITEMS) send_word(random_word());
		end
	endtask

	// the two latches shut each other out, so one run takes one of them
	task automatic test_latched_fault();
		set_policy('1, '1);
		send_word(make_word(MODE_STOP, now_ms, 1'b0, 1'b0, SINK_ACCEPTED));
		if ($urandom_range(0, 1)) begin
			// due time past the top of 64 bits
			now_ms = 64'hFFFF_FFFF_FFFF_FF00;
			send_word(make_word(MODE_START, now_ms, 1'b1, 1'b1, SINK_ACCEPTED));
			send_word(make_word(MODE_SERVICE, now_ms, 1'b1, 1'b1, SINK_ACCEPTED));
			now_ms = '1;
			send_word(make_word(MODE_SERVICE, now_ms, 1'b1, 1'b1, SINK_ACCEPTED));
		end else begin
			// time stepping back by one
			now_ms = now_ms + 10;
			send_word(make_word(MODE_START, now_ms, 1'b1, 1'b1, SINK_ACCEPTED));
			send_word(make_word(MODE_SERVICE, now_ms - 1, 1'b1, 1'b1, SINK_ACCEPTED));
			send_word(make_word(MODE_SERVICE, now_ms, 1'b1, 1'b1, SINK_ACCEPTED));
		end
		send_word(make_word(MODE_START, now_ms, 1'b1, 1'b1, SINK_ACCEPTED));
		// everything after stays failed
		repeat (20) send_word(random_word());
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	// each returned word against the oldest owed one
	always @(posedge clk) begin : check_results
		brs_out_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready) begin
			if (predicted_words.size() == 0) begin
				mismatch_count++;
				$display("%0t ns: word expected none actual %0h", $time, out_item);
			end else begin
				want = predicted_words.pop_front();
				compare_field("disposition", 64'(want.disposition), 64'(out_item.disposition));
				compare_field("error_code", 64'(want.error_code), 64'(out_item.error_code));
				compare_field("next_due", want.next_due, out_item.next_due);
				compare_field("is_active", 64'(want.is_active), 64'(out_item.is_active));
				compare_field("clock_fault", 64'(want.clock_fault), 64'(out_item.clock_fault));
				compare_field("exhausted", 64'(want.exhausted), 64'(out_item.exhausted));
				compare_field("submitted_count", 64'(want.submitted_count),
					64'(out_item.submitted_count));
				compare_field("backpressure_count", 64'(want.backpressure_count),
					64'(out_item.backpressure_count));
				compare_field("suppressed_count", 64'(want.suppressed_count),
					64'(out_item.suppressed_count));
				compare_field("failure_count", 64'(want.failure_count),
					64'(out_item.failure_count));
				compare_field("service_count", 64'(want.service_count),
					64'(out_item.service_count));
				compare_field("start_attempt_count", 64'(want.start_attempt_count),
					64'(out_item.start_attempt_count));
			end
		end
	end

	// receiver stalls, switching pattern whenever rx_tick wraps
	always @(negedge clk) begin
		if (rx_tick == 0) begin
			rx_pattern = rx_pattern_t'($urandom_range(0, 3));
		end
		case (rx_pattern)
			RX_OPEN: out_ready = 1'b1;
			RX_COIN: out_ready = 1'($urandom_range(0, 1));
			RX_SPARSE: out_ready = ((rx_tick % 4) == 0);
			default: out_ready = ($urandom_range(0, 7) != 0);
		endcase
		rx_tick = (rx_tick == 39) ? 0 : rx_tick + 1;
	end

	// hang guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_CADENCE;
		cfg_data = '0;
		// mirror starts from the reset state
		cad_period = CADENCE_RESET;
		rty_period = RETRY_RESET;
		sched_active = 1'b0;
		next_at = '0;
		last_seen_ms = '0;
		seen_any_time = 1'b0;
		clk_fault = 1'b0;
		due_overflow = 1'b0;
		last_err = ERR_NONE;
		n_submit = '0;
		n_backpr = '0;
		n_suppress = '0;
		n_failure = '0;
		n_service = '0;
		n_start = '0;
		now_ms = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_idle_items();
		test_service_outcomes();
		test_policy_invalid();
		test_delay_extremes();
		test_random_traffic();
		test_latched_fault();

		// drain, then give a stray word time to show up
		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
